>>> src/cqs_pkg.sv
// shared constants for the circular queue with search
package cqs_pkg;

  localparam int VALUE_W  = 32;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;

  // slave-side and master-side tdata widths, padded to whole bytes
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 40;

  // request kinds
  localparam logic [OP_W-1:0] OP_ENQ  = 2'd0;
  localparam logic [OP_W-1:0] OP_DEQ  = 2'd1;
  localparam logic [OP_W-1:0] OP_SRCH = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_OVER  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_UNDER = 2'd2;

  typedef logic signed [VALUE_W-1:0] value_t;

endpackage

>>> src/cqs_ram.sv
// generic single-port ram with registered read
module cqs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> src/circular_queue_with_search_top.sv
// top level of the circular queue with search
//
// channel   dir  tdata                                   tuser
// s_axis    in   [31:0] value_in                         [1:0] op
// m_axis    out  [31:0] value_out, [32] found,           [1:0] status
//                [33] is_full, [34] is_empty, rest zero
//
// enqueue, failed dequeue, empty search and unknown op answer in the
//   cycle after the request; a dequeue reads the entry memory, then loads the
//   output register from S_DEQ; a search reads the occupied entries oldest first,
//   one entry a cycle through the single read/write port of the entry memory
// reset: rst clears the pointers, the occupancy, the sequencer and the
//   output valid; entry memory contents are left as they are
// stalls: one request is in work at a time; s_axis_tready is low while a
//   dequeue or search is in work, or while a held result is not taken
module circular_queue_with_search_top #(
  parameter int DEPTH = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  // request channel
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [cqs_pkg::IN_DATA_W-1:0]  s_axis_tdata,   // [31:0] value_in
  input  logic [cqs_pkg::OP_W-1:0]       s_axis_tuser,   // [1:0] op
  // result channel
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [cqs_pkg::OUT_DATA_W-1:0] m_axis_tdata,   // [31:0] value_out, [32] found,
                                                         // [33] is_full, [34] is_empty
  output logic [cqs_pkg::STATUS_W-1:0]   m_axis_tuser    // [1:0] status
);

  localparam int AW = $clog2(DEPTH);
  localparam int OW = $clog2(DEPTH + 1);

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DEQ  = 2'd1;
  localparam logic [1:0] S_SRCH = 2'd2;

  function automatic logic [AW-1:0] inc_idx(input logic [AW-1:0] idx);
    logic [AW-1:0] r;
    if (idx == AW'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = idx + 1'b1;
    end
    return r;
  endfunction

  logic [1:0]     state, state_next;
  logic [AW-1:0]  head, head_next;
  logic [AW-1:0]  tail, tail_next;
  logic [OW-1:0]  occ, occ_next;
  logic [AW-1:0]  scan_idx, scan_idx_next;
  logic [OW-1:0]  scan_left, scan_left_next;
  logic           found, found_next;
  cqs_pkg::value_t key, key_next;

  // memory port
  logic           ram_we;
  logic [AW-1:0]  ram_addr;
  cqs_pkg::value_t ram_rdata;

  // result being loaded into the output register
  logic                          out_load;
  logic [cqs_pkg::STATUS_W-1:0]  res_status;
  cqs_pkg::value_t               res_value;
  logic                          res_found;
  logic                          match;

  // output register
  logic                          out_valid;
  logic [cqs_pkg::STATUS_W-1:0]  out_status;
  cqs_pkg::value_t               out_value;
  logic                          out_found;
  logic                          out_full;
  logic                          out_empty;

  logic accept;
  logic q_full;
  logic q_empty;

  assign q_full        = (occ == OW'(DEPTH));
  assign q_empty       = (occ == '0);
  assign s_axis_tready = (state == S_IDLE) && (!out_valid || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign match         = found || (ram_rdata == key);

  cqs_ram #(
    .WIDTH (cqs_pkg::VALUE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (s_axis_tdata[cqs_pkg::VALUE_W-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next     = state;
    head_next      = head;
    tail_next      = tail;
    occ_next       = occ;
    scan_idx_next  = scan_idx;
    scan_left_next = scan_left;
    found_next     = found;
    key_next       = key;
    ram_we         = 1'b0;
    ram_addr       = scan_idx;
    out_load       = 1'b0;
    res_status     = cqs_pkg::STATUS_OK;
    res_value      = '0;
    res_found      = 1'b0;

    case (state)
      S_IDLE: begin
        if (accept) begin
          case (s_axis_tuser)
            cqs_pkg::OP_ENQ: begin
              out_load = 1'b1;
              if (q_full) begin
                res_status = cqs_pkg::STATUS_OVER;
              end else begin
                ram_we    = 1'b1;
                ram_addr  = tail;
                tail_next = inc_idx(tail);
                occ_next  = occ + 1'b1;
              end
            end
            cqs_pkg::OP_DEQ: begin
              if (q_empty) begin
                out_load   = 1'b1;
                res_status = cqs_pkg::STATUS_UNDER;
                res_value  = '1;
              end else begin
                // read the oldest entry, data shows up next cycle
                ram_addr   = head;
                head_next  = inc_idx(head);
                occ_next   = occ - 1'b1;
                state_next = S_DEQ;
              end
            end
            cqs_pkg::OP_SRCH: begin
              if (q_empty) begin
                out_load = 1'b1;
              end else begin
                // first read at head, then one entry a cycle
                ram_addr       = head;
                scan_idx_next  = inc_idx(head);
                scan_left_next = occ;
                found_next     = 1'b0;
                key_next       = s_axis_tdata[cqs_pkg::VALUE_W-1:0];
                state_next     = S_SRCH;
              end
            end
            default: begin
              // unknown op leaves the state alone
              out_load = 1'b1;
            end
          endcase
        end
      end
      S_DEQ: begin
        out_load   = 1'b1;
        res_value  = ram_rdata;
        state_next = S_IDLE;
      end
      S_SRCH: begin
        found_next     = match;
        scan_left_next = scan_left - 1'b1;
        if (scan_left == OW'(1)) begin
          out_load   = 1'b1;
          res_found  = match;
          state_next = S_IDLE;
        end else begin
          ram_addr      = scan_idx;
          scan_idx_next = inc_idx(scan_idx);
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      tail      <= '0;
      occ       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      tail  <= tail_next;
      occ   <= occ_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload and scan registers
  always_ff @(posedge clk) begin
    scan_idx  <= scan_idx_next;
    scan_left <= scan_left_next;
    found     <= found_next;
    key       <= key_next;
    if (out_load) begin
      out_status <= res_status;
      out_value  <= res_value;
      out_found  <= res_found;
      // flags as they stand after this request
      out_full   <= (occ_next == OW'(DEPTH));
      out_empty  <= (occ_next == '0);
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_status;
  assign m_axis_tdata  = {5'b0, out_empty, out_full, out_found, out_value};

endmodule

>>> test/tb_circular_queue_with_search_top.sv
// testbench for the circular queue with search, checked against a queue model
`timescale 1ns / 100ps

module tb_circular_queue_with_search_top;

  localparam int DEPTH = 8;
  localparam int RANDOM_REQUESTS = 450;
  // op code the block must ignore
  localparam logic [cqs_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [cqs_pkg::OP_W-1:0] op;
    cqs_pkg::value_t          value;
  } request_t;

  typedef struct packed {
    logic [cqs_pkg::STATUS_W-1:0] status;
    cqs_pkg::value_t              value_out;
    logic                         found;
    logic                         is_full;
    logic                         is_empty;
  } result_t;

  // all block inputs start known
  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [cqs_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [cqs_pkg::OP_W-1:0]       s_axis_tuser = '0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [cqs_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic [cqs_pkg::STATUS_W-1:0]   m_axis_tuser;

  // stimulus waiting to be sent, and results the queue model predicts
  request_t pending_requests[$];
  result_t  expected_results[$];

  // shadow of the queue contents while the stimulus is built, used to aim searches
  cqs_pkg::value_t planned_contents[$];
  int              planned_count = 0;

  // queue model state
  cqs_pkg::value_t model_mem[DEPTH];
  int unsigned     model_head = 0;
  int unsigned     model_tail = 0;
  int unsigned     model_count = 0;

  // run statistics
  int mismatch_count = 0;
  int op_seen[4] = '{0, 0, 0, 0};
  int overflow_seen = 0;
  int underflow_seen = 0;
  int hit_seen = 0;
  int full_seen = 0;

  // sender burst state
  int       burst_left = 1;
  int       gap_left = 0;
  request_t next_req;

  // receiver stall state
  int rx_cycle = 0;
  int stall_left = 0;

  circular_queue_with_search_top #(
    .DEPTH(DEPTH)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #2 clk = ~clk;

  // applies one request to the queue model and returns the result it should give
  function automatic result_t predict_queue_result(request_t req);
    result_t r;
    r = '0;
    op_seen[req.op]++;
    case (req.op)
      cqs_pkg::OP_ENQ: begin
        if (model_count == DEPTH) begin
          r.status = cqs_pkg::STATUS_OVER;
          overflow_seen++;
        end else begin
          model_mem[model_tail] = req.value;
          model_tail = (model_tail + 1) % DEPTH;
          model_count++;
        end
      end
      cqs_pkg::OP_DEQ: begin
        if (model_count == 0) begin
          r.status = cqs_pkg::STATUS_UNDER;
          r.value_out = '1;
          underflow_seen++;
        end else begin
          r.value_out = model_mem[model_head];
          model_head = (model_head + 1) % DEPTH;
          model_count--;
        end
      end
      cqs_pkg::OP_SRCH: begin
        // only the occupied entries, oldest first
        for (int n = 0; n < model_count; n++) begin
          if (model_mem[(model_head + n) % DEPTH] == req.value) r.found = 1'b1;
        end
        if (r.found) hit_seen++;
      end
      default: ;
    endcase
    r.is_full = (model_count == DEPTH);
    r.is_empty = (model_count == 0);
    if (r.is_full) full_seen++;
    return r;
  endfunction

  // queues one request and tracks what the queue will hold
  function automatic void add_request(logic [cqs_pkg::OP_W-1:0] op, cqs_pkg::value_t value);
    request_t req;
    req.op = op;
    req.value = value;
    pending_requests.push_back(req);
    if (op != OP_UNUSED) planned_count++;
    if (op == cqs_pkg::OP_ENQ && planned_contents.size() < DEPTH) begin
      planned_contents.push_back(value);
    end else if (op == cqs_pkg::OP_DEQ && planned_contents.size() > 0) begin
      planned_contents.delete(0);
    end
  endfunction

  // extremes and small values make collisions likely, the rest is full-width random
  function automatic cqs_pkg::value_t pick_value();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      1: return cqs_pkg::value_t'(int'($urandom_range(0, 8)) - 4);
      default: return $urandom;
    endcase
  endfunction

  // search value: mostly one that should be held, else anything
  function automatic cqs_pkg::value_t pick_target();
    if (planned_contents.size() > 0 && $urandom_range(0, 2) != 0) begin
      return planned_contents[$urandom_range(0, planned_contents.size() - 1)];
    end
    return pick_value();
  endfunction

  task automatic report_mismatch(string what, logic [cqs_pkg::OUT_DATA_W-1:0] got,
                                 logic [cqs_pkg::OUT_DATA_W-1:0] want);
    // keep the log short on a broken block, but count everything
    if (mismatch_count < 40) begin
      $display("%0t ns: mismatch on %s, got %h, want %h", $time, what, got, want);
    end
    mismatch_count++;
  endtask

  // sender: bursts of random length with random gaps between them
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      // a request taken at this edge updates the model
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.push_back(predict_queue_result(request_t'({s_axis_tuser, s_axis_tdata})));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          s_axis_tvalid <= 1'b0;
        end else if (pending_requests.size() != 0) begin
          next_req = pending_requests.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser <= next_req.op;
          s_axis_tdata <= next_req.value;
          if (burst_left <= 1) begin
            // new burst; some bursts follow with no gap at all
            burst_left <= $urandom_range(1, 24);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each result and stalls on its own pattern
  always @(posedge clk) begin
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with no request outstanding", m_axis_tdata, '0);
      end else begin
        want = expected_results.pop_front();
        if (m_axis_tuser !== want.status) begin
          report_mismatch("status", cqs_pkg::OUT_DATA_W'(m_axis_tuser),
                          cqs_pkg::OUT_DATA_W'(want.status));
        end
        if (m_axis_tdata[31:0] !== want.value_out) begin
          report_mismatch("value_out", cqs_pkg::OUT_DATA_W'(m_axis_tdata[31:0]),
                          cqs_pkg::OUT_DATA_W'(want.value_out));
        end
        if (m_axis_tdata[32] !== want.found) begin
          report_mismatch("found", cqs_pkg::OUT_DATA_W'(m_axis_tdata[32]),
                          cqs_pkg::OUT_DATA_W'(want.found));
        end
        if (m_axis_tdata[33] !== want.is_full) begin
          report_mismatch("is_full", cqs_pkg::OUT_DATA_W'(m_axis_tdata[33]),
                          cqs_pkg::OUT_DATA_W'(want.is_full));
        end
        if (m_axis_tdata[34] !== want.is_empty) begin
          report_mismatch("is_empty", cqs_pkg::OUT_DATA_W'(m_axis_tdata[34]),
                          cqs_pkg::OUT_DATA_W'(want.is_empty));
        end
        if (m_axis_tdata[cqs_pkg::OUT_DATA_W-1:35] !== '0) begin
          report_mismatch("tdata padding", m_axis_tdata, '0);
        end
      end
    end
    // stretches of always ready, coin-flip ready, and long stalls
    rx_cycle <= rx_cycle + 1;
    case ((rx_cycle / 150) % 3)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom_range(0, 1));
      default: begin
        if (stall_left != 0) begin
          stall_left <= stall_left - 1;
          m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
          stall_left <= $urandom_range(1, 10);
          m_axis_tready <= 1'b0;
        end else begin
          m_axis_tready <= 1'b1;
        end
      end
    endcase
  end

  // stimulus, reset and end of run
  initial begin
    int                        len;
    logic [cqs_pkg::OP_W-1:0]  op;

    // empty queue corner cases: underflow, search and ignored op
    add_request(cqs_pkg::OP_DEQ, 32'h1234_5678);
    add_request(cqs_pkg::OP_SRCH, 32'h0);
    add_request(OP_UNUSED, 32'hFFFF_FFFF);
    // field extremes
    add_request(cqs_pkg::OP_ENQ, 32'h7FFF_FFFF);
    add_request(cqs_pkg::OP_ENQ, 32'h8000_0000);
    add_request(cqs_pkg::OP_ENQ, 32'hFFFF_FFFF);
    add_request(cqs_pkg::OP_ENQ, 32'h0);
    add_request(cqs_pkg::OP_SRCH, 32'h8000_0000);
    add_request(cqs_pkg::OP_SRCH, 32'd12345);
    // fill to the top, then overflow
    add_request(cqs_pkg::OP_ENQ, 32'd1);
    add_request(cqs_pkg::OP_ENQ, 32'd2);
    add_request(cqs_pkg::OP_ENQ, 32'd3);
    add_request(cqs_pkg::OP_ENQ, 32'h5555_5555);
    add_request(cqs_pkg::OP_ENQ, 32'hAAAA_AAAA);
    // searches over a full queue, newest entry last
    add_request(cqs_pkg::OP_SRCH, 32'hAAAA_AAAA);
    add_request(cqs_pkg::OP_SRCH, 32'h5555_5555);
    add_request(OP_UNUSED, 32'h0);
    // dequeue then wrap the tail around
    add_request(cqs_pkg::OP_DEQ, 32'h0);
    add_request(cqs_pkg::OP_ENQ, 32'hAAAA_AAAA);
    add_request(cqs_pkg::OP_SRCH, 32'h7FFF_FFFF);
    add_request(cqs_pkg::OP_SRCH, 32'hAAAA_AAAA);
    add_request(cqs_pkg::OP_DEQ, 32'hFFFF_FFFF);
    add_request(cqs_pkg::OP_DEQ, 32'h0);

    // random episodes: fills, drains, mixed traffic and a little noise
    planned_count = 0;
    while (planned_count < RANDOM_REQUESTS) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          len = $urandom_range(1, DEPTH + 3);
          for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 3) == 0) add_request(cqs_pkg::OP_SRCH, pick_target());
            else add_request(cqs_pkg::OP_ENQ, pick_value());
          end
        end
        3, 4, 5: begin
          len = $urandom_range(1, DEPTH + 3);
          for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 4) == 0) add_request(cqs_pkg::OP_SRCH, pick_target());
            else add_request(cqs_pkg::OP_DEQ, $urandom);
          end
        end
        6, 7, 8: begin
          len = $urandom_range(4, 16);
          for (int k = 0; k < len; k++) begin
            op = cqs_pkg::OP_W'($urandom_range(0, 2));
            add_request(op, (op == cqs_pkg::OP_SRCH) ? pick_target() : pick_value());
          end
        end
        default: begin
          len = $urandom_range(1, 4);
          for (int k = 0; k < len; k++) begin
            op = $urandom_range(0, 1) ? OP_UNUSED : cqs_pkg::OP_W'($urandom_range(0, 3));
            add_request(op, $urandom);
          end
        end
      endcase
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // everything sent and taken
    while (pending_requests.size() != 0 || s_axis_tvalid) @(posedge clk);
    // every result back
    while (expected_results.size() != 0) @(posedge clk);
    // room for a stray extra result to show up
    repeat (DEPTH + 4) @(posedge clk);

    $display("covered %0d requests: %0d enqueue, %0d dequeue, %0d search, %0d ignored op",
             op_seen[0] + op_seen[1] + op_seen[2] + op_seen[3],
             op_seen[0], op_seen[1], op_seen[2], op_seen[3]);
    $display("%0d overflows, %0d underflows, %0d search hits, %0d results with queue full",
             overflow_seen, underflow_seen, hit_seen, full_seen);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
